FILE: hdl/spd_pkg.sv
// Package for the serial packet deframer: transaction payload types and
// framing constants. No dependencies; imported by the top level.
`default_nettype none

package spd_pkg;

   localparam logic [7:0] SYNC_FIRST   = 8'hAA;
   localparam logic [7:0] SYNC_SECOND  = 8'h55;
   localparam logic [7:0] HEADER_BYTES = 8'd4;

   // Byte position codes for the header phase; payload starts at POS_PAYLOAD.
   localparam logic [7:0] POS_HUNT     = 8'd0;
   localparam logic [7:0] POS_SYNC2    = 8'd1;
   localparam logic [7:0] POS_LENGTH   = 8'd2;
   localparam logic [7:0] POS_CHECKSUM = 8'd3;
   localparam logic [7:0] POS_PAYLOAD  = 8'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       line_error;
   } req_payload_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [5:0] payload_index;
      logic [1:0] slot;
      logic       frame_good;
      logic       frame_bad;
      logic [7:0] payload_length;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: hdl/spd_stream_if.sv
// Valid/ready stream interface used for the deframer's byte and result channels.
// Depends on nothing; the payload type is given by the instantiating code.
`default_nettype none

interface spd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/serial_packet_deframer.sv
// Serial packet deframer top level: sync hunt, length check, checksum, ring slot.
// Depends on spd_pkg and spd_stream_if.
// A byte passes from acceptance through the input register, then the result register.
// Throughput: one byte per cycle while the result channel is ready; the per-byte state update is one short add/compare.
// Reset (synchronous): hunting for sync, sum, length and slot cleared, both
// pipeline registers empty.
`default_nettype none

module serial_packet_deframer
   import spd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64,
   parameter int SLOTS       = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   spd_stream_if.sink   req_chan,
   spd_stream_if.source rsp_chan
);

   localparam logic [7:0] LIMIT = 8'(MAX_PAYLOAD + 4);
   localparam logic [4:0] SLOT_WRAP = 5'(SLOTS);

   // Input register
   logic            in_valid_ff;
   req_payload_type in_data_ff;

   // Frame state
   logic [7:0] byte_position_ff, byte_position_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] declared_length_ff, declared_length_in;
   logic [1:0] write_slot_ff, write_slot_in;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic advance;
   logic [7:0] b;
   logic [7:0] pos_next;
   logic [7:0] sum_next;
   logic [4:0] slot_inc;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign b        = in_data_ff.rx_byte;
   assign pos_next = byte_position_ff + 8'd1;
   assign sum_next = running_sum_ff + b;
   assign slot_inc = {3'b000, write_slot_ff} + 5'd1;

   always_comb begin
      byte_position_in   = byte_position_ff;
      running_sum_in     = running_sum_ff;
      declared_length_in = declared_length_ff;
      write_slot_in      = write_slot_ff;
      rsp_data_in        = '0;
      rsp_data_in.slot   = write_slot_ff;

      if (!in_data_ff.line_error) begin
         if (byte_position_ff == POS_HUNT) begin
            if (b == SYNC_FIRST) begin
               running_sum_in   = SYNC_FIRST;
               byte_position_in = POS_SYNC2;
            end
         end else if (byte_position_ff == POS_SYNC2) begin
            if (b == SYNC_SECOND) begin
               byte_position_in = POS_LENGTH;
               running_sum_in   = sum_next;
            end else if (b != SYNC_FIRST) begin
               byte_position_in = POS_HUNT;
            end
         end else if (byte_position_ff == POS_LENGTH) begin
            declared_length_in = b;
            if (b > LIMIT) begin
               byte_position_in = POS_HUNT;
            end else begin
               byte_position_in = POS_CHECKSUM;
               running_sum_in   = sum_next;
            end
         end else if (byte_position_ff == POS_CHECKSUM) begin
            byte_position_in = POS_PAYLOAD;
            running_sum_in   = sum_next;
         end else if (byte_position_ff < LIMIT) begin
            rsp_data_in.payload_valid = 1'b1;
            rsp_data_in.payload_byte  = b;
            rsp_data_in.payload_index = 6'(byte_position_ff - HEADER_BYTES);
            byte_position_in = pos_next;
            running_sum_in   = sum_next;
            // close the frame once the declared length is reached
            if (pos_next >= declared_length_ff) begin
               if (sum_next == 8'd0) begin
                  rsp_data_in.frame_good     = 1'b1;
                  rsp_data_in.payload_length = declared_length_ff - HEADER_BYTES;
                  write_slot_in = (slot_inc >= SLOT_WRAP) ? 2'd0 : slot_inc[1:0];
               end else begin
                  rsp_data_in.frame_bad = 1'b1;
               end
               byte_position_in   = POS_HUNT;
               declared_length_in = 8'd0;
            end
         end else begin
            byte_position_in = POS_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         byte_position_ff   <= POS_HUNT;
         running_sum_ff     <= 8'd0;
         declared_length_ff <= 8'd0;
         write_slot_ff      <= 2'd0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff       <= 1'b1;
            byte_position_ff   <= byte_position_in;
            running_sum_ff     <= running_sum_in;
            declared_length_ff <= declared_length_in;
            write_slot_ff      <= write_slot_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // A frame end is only ever reported on a payload byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.frame_good || rsp_data_ff.frame_bad)
         |-> rsp_data_ff.payload_valid)
      else $error("frame end reported without payload byte");

   // A byte with a line error leaves the frame state untouched
   assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.line_error
         |=> $stable(byte_position_ff) && $stable(running_sum_ff)
             && $stable(declared_length_ff) && $stable(write_slot_ff))
      else $error("line error byte changed frame state");

   // The ring slot moves only on a committed frame
   assert property (@(posedge clock) disable iff (reset)
      !(advance && rsp_data_in.frame_good) |=> $stable(write_slot_ff))
      else $error("write slot moved without a good frame");

   // Result register never drops a waiting transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result lost");

endmodule

`default_nettype wire
